// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ffha_pkg.sv =====
package ffha_pkg;

    localparam int DEF_ARENA_PAGES = 64;
    localparam int DEF_PAGE_WORDS  = 512;
    localparam int ALIGN_SHIFT     = 3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_ZEROBLK = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [18:0] req_bytes;
        logic [17:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] payload_offset;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SPLIT,
        S_F_RD,
        S_F_MARK,
        S_M_RD,
        S_M_RDN,
        S_M_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic rd_nxt;
        logic wr_taken;
        logic wr_split;
        logic wr_mark;
        logic wr_merge;
        logic adv;
        logic set_nofit;
        logic set_zero;
        logic set_ok;
        logic fire;
    } t_cmd;

    typedef struct packed {
        logic req_free;
        logic null_free;
        logic h_oob;
        logic pos_end;
        logic sz_zero;
        logic fit;
        logic need_split;
        logic nxt_end;
        logic nsz_zero;
        logic both_free;
        logic h_free;
    } t_sts;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// Allocate: a header read and a fit check per block visited on the chain, then a split step if needed.
// Free: marks the block free, then merge or advance steps in a pass over the whole arena.
// Free below offset 8 is a null free and returns ST_OK. The header memory read paces the chain walk.
// One item at a time; the next item is accepted in the cycle o_strobe is high.
// The result shows on o_strobe for one cycle; no stall from the receiver.
// Synchronous active-low reset sets header word 0 to one free block of the arena.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int ARENA_PAGES = DEF_ARENA_PAGES,
    parameter int PAGE_WORDS  = DEF_PAGE_WORDS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ffha_dp #(
        .ARENA_PAGES (ARENA_PAGES),
        .PAGE_WORDS  (PAGE_WORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_F_RD;
            end
            S_F_RD: begin
                if (!i_sts.req_free) n_state = S_A_RD;
                else if (i_sts.null_free) n_state = S_DONE;
                else n_state = S_F_MARK;
            end
            S_F_MARK:  n_state = S_M_RD;
            S_A_RD: begin
                if (i_sts.pos_end) n_state = S_DONE;
                else n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_sts.sz_zero) n_state = S_DONE;
                else if (i_sts.fit) n_state = i_sts.need_split ? S_A_SPLIT : S_DONE;
                else n_state = S_A_RD;
            end
            S_A_SPLIT: n_state = S_DONE;
            S_M_RD: begin
                if (i_sts.pos_end) n_state = S_DONE;
                else n_state = S_M_RDN;
            end
            S_M_RDN: begin
                if (i_sts.sz_zero || i_sts.nxt_end) n_state = S_DONE;
                else n_state = S_M_CHK;
            end
            S_M_CHK: begin
                if (i_sts.nsz_zero) n_state = S_DONE;
                else if (i_sts.both_free) n_state = S_M_RD;
                else n_state = S_M_RD;
            end
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_F_RD: begin
                if (!i_sts.req_free) begin
                    o_cmd.rd_pos = 1'b1;
                end else if (i_sts.null_free) begin
                    o_cmd.set_ok = 1'b1;
                end else begin
                    o_cmd.rd_pos = 1'b1;
                end
            end
            S_F_MARK: begin
                o_cmd.wr_mark = !i_sts.h_free && !i_sts.h_oob;
                o_cmd.rd_pos  = 1'b1;
            end
            S_A_RD: begin
                if (i_sts.pos_end) o_cmd.set_nofit = 1'b1;
            end
            S_A_CHK: begin
                if (i_sts.sz_zero) begin
                    o_cmd.set_zero = 1'b1;
                end else if (i_sts.fit) begin
                    o_cmd.wr_taken = 1'b1;
                    o_cmd.set_ok   = 1'b1;
                end else begin
                    o_cmd.adv    = 1'b1;
                    o_cmd.rd_pos = 1'b1;
                end
            end
            S_A_SPLIT: begin
                o_cmd.wr_split = 1'b1;
            end
            S_M_RD: begin
                if (i_sts.pos_end) o_cmd.set_ok = 1'b1;
                else o_cmd.rd_nxt = 1'b1;
            end
            S_M_RDN: begin
                if (i_sts.sz_zero) o_cmd.set_zero = 1'b1;
                else if (i_sts.nxt_end) o_cmd.set_ok = 1'b1;
            end
            S_M_CHK: begin
                if (i_sts.nsz_zero) begin
                    o_cmd.set_zero = 1'b1;
                end else if (i_sts.both_free) begin
                    o_cmd.wr_merge = 1'b1;
                    o_cmd.rd_pos   = 1'b1;
                end else begin
                    o_cmd.adv    = 1'b1;
                    o_cmd.rd_pos = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.fire = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/ffha_dp.sv =====
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int ARENA_PAGES = DEF_ARENA_PAGES,
    parameter int PAGE_WORDS  = DEF_PAGE_WORDS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int TOTAL = ARENA_PAGES * PAGE_WORDS;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(TOTAL + 1);
    localparam int PW    = AW + 2;

    // header: {free, size}
    logic [SW:0] r_mem [TOTAL];
    logic [SW:0] r_rdata;

    logic        r_req_free;
    logic [PW-1:0] r_need;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_h;
    logic        r_cur_free;
    logic [SW-1:0] r_cur_sz;
    logic [1:0]  r_status;
    logic [17:0] r_pay;
    logic        r_strobe;
    logic        r_first;
    logic        r_lat;

    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] nxt;
    logic [PW-1:0] split_at;
    logic [PW-1:0] rest;
    logic        we;
    logic [AW-1:0] wa;
    logic [SW:0] wd;
    logic [SW:0] rdat;
    logic        cur_free_v;
    logic [SW-1:0] cur_sz_v;

    assign rdat = r_rdata;

    assign cur_free_v = r_lat ? rdat[SW] : r_cur_free;
    assign cur_sz_v   = r_lat ? rdat[SW-1:0] : r_cur_sz;

    assign nxt      = r_pos + PW'(cur_sz_v);
    assign split_at = r_pos + r_need;
    assign rest     = PW'(r_cur_sz) - r_need;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_pos[AW-1:0];
        if (i_cmd.rd_nxt) begin
            rd_en   = 1'b1;
            rd_addr = nxt[AW-1:0];
        end else if (i_cmd.rd_pos) begin
            rd_en = 1'b1;
            if (i_cmd.adv) rd_addr = nxt[AW-1:0];
            else if (r_first && r_req_free) rd_addr = r_h[AW-1:0];
            else rd_addr = r_pos[AW-1:0];
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_pos[AW-1:0];
        wd = {1'b0, r_cur_sz};
        if (i_cmd.wr_taken) begin
            we = 1'b1;
            wd = {1'b0, (rest > PW'(1)) ? SW'(r_need) : r_cur_sz};
        end else if (i_cmd.wr_split) begin
            we = 1'b1;
            wa = split_at[AW-1:0];
            wd = {1'b1, SW'(rest)};
        end else if (i_cmd.wr_mark) begin
            we = 1'b1;
            wa = r_h[AW-1:0];
            wd = {1'b1, rdat[SW-1:0]};
        end else if (i_cmd.wr_merge) begin
            we = 1'b1;
            wd = {1'b1, r_cur_sz + rdat[SW-1:0]};
        end
    end

    // Forward a write to the word read at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mem[0] <= {1'b1, SW'(TOTAL)};
        else if (we) r_mem[wa] <= wd;
        if (rd_en) r_rdata <= (we && (wa == rd_addr)) ? wd : r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.fire;
        end
        if (i_cmd.load) begin
            r_req_free <= i_req.req_type == REQ_FREE;
            r_need     <= PW'((20'(i_req.req_bytes) + 20'd7) >> ALIGN_SHIFT) + PW'(1);
            r_h        <= PW'(i_req.free_offset >> ALIGN_SHIFT) - PW'(1);
            r_pos      <= '0;
            r_first    <= 1'b1;
            r_pay      <= '0;
            r_status   <= ST_OK;
        end
        if (i_cmd.rd_pos || i_cmd.rd_nxt) r_first <= 1'b0;
        if (i_cmd.adv) r_pos <= nxt;
        if (i_cmd.wr_merge) r_cur_sz <= r_cur_sz + rdat[SW-1:0];
        if (i_cmd.set_ok) begin
            r_status <= ST_OK;
            if (!r_req_free) r_pay <= 18'((r_pos + PW'(1)) << ALIGN_SHIFT);
        end
        if (i_cmd.set_nofit) r_status <= ST_NOFIT;
        if (i_cmd.set_zero) begin
            r_status <= ST_ZEROBLK;
            r_pay    <= '0;
        end
        if (r_lat) begin
            r_cur_free <= rdat[SW];
            r_cur_sz   <= rdat[SW-1:0];
        end
        if (i_cmd.wr_mark) r_cur_free <= 1'b1;
    end

    // Flag the cycle after a current-position read, when its header is latched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= 1'b0;
        end else begin
            r_lat <= rd_en && !i_cmd.rd_nxt && !(r_first && r_req_free);
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.req_free   = r_req_free;
        o_sts.null_free  = (r_h == {PW{1'b1}});
        o_sts.h_oob      = (r_h >= PW'(TOTAL)) && !o_sts.null_free;
        o_sts.pos_end    = (r_pos >= PW'(TOTAL));
        o_sts.sz_zero    = (cur_sz_v == '0);
        o_sts.fit        = cur_free_v && (r_need <= PW'(cur_sz_v));
        o_sts.need_split = (rest > PW'(1)) && (split_at < PW'(TOTAL));
        o_sts.nxt_end    = (nxt >= PW'(TOTAL));
        o_sts.nsz_zero   = (rdat[SW-1:0] == '0);
        o_sts.both_free  = r_cur_free && rdat[SW];
        o_sts.h_free     = rdat[SW];
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = '{status: r_status, payload_offset: r_pay};

endmodule

// ===== rtl/core/ffha_checker.sv =====
`include "assert_macros.svh"

module ffha_checker
    import ffha_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_rsp
);

    `ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `ASSERT_IMPL(a_strobe_busy, o_strobe, !busy)
    `ASSERT_IMPL(a_status_range, o_strobe, o_rsp.status <= ST_ZEROBLK)
    `ASSERT_IMPL(a_pay_zero, o_strobe && o_rsp.status != ST_OK, o_rsp.payload_offset == '0)

endmodule

bind first_fit_heap_allocator ffha_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
